@@ hw/rtl/blr_pkg.sv @@
// Package for the Bresenham line rasterizer: coordinate and error widths,
// opcodes and the packed beat types of the item and pixel channels.
// No dependencies.
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 8;
    localparam int ERR_BITS   = COORD_BITS + 2;

    typedef logic [COORD_BITS-1:0]   coord_t;
    typedef logic [COLOR_BITS-1:0]   color_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t    op;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t red;
        color_t green;
        color_t blue;
    } item_t;

    typedef struct packed
    {
        logic   valid_res;
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_red;
        color_t pixel_green;
        color_t pixel_blue;
        logic   last;
    } pixel_t;

endpackage

`default_nettype wire

@@ hw/rtl/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer, all octants, one pixel per item.
// An accepted item beat's pixel beat is registered and shows in the next cycle.
// Throughput: 1 item per cycle while pixel_stall is low; error step and state
// update are combinational, and out_reg is refilled in the cycle it drains.
// Reset: asynchronous, active low; no line active and no pixel pending.
// Depends on blr_pkg.
`default_nettype none

module bresenham_line_rasterizer
    import blr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   item_valid,
    output logic        item_stall,
    input  wire item_t  item,
    output logic        pixel_valid,
    input  wire logic   pixel_stall,
    output pixel_t      pixel
);

    localparam int EXT_BITS = ERR_BITS + 1;

    typedef logic signed [EXT_BITS-1:0] ext_t;

    coord_t cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    coord_t span_x_reg, span_y_reg;
    logic   neg_x_reg, neg_y_reg;
    err_t   err_reg;
    color_t red_reg, green_reg, blue_reg;
    logic   active_reg;
    logic   out_valid_reg;
    pixel_t out_reg;

    coord_t cur_x_next, cur_y_next, tgt_x_next, tgt_y_next;
    coord_t span_x_next, span_y_next;
    logic   neg_x_next, neg_y_next;
    err_t   err_next;
    color_t red_next, green_next, blue_next;
    logic   active_next;
    pixel_t out_next;

    logic   accept;
    logic   at_end;
    logic   step_x, step_y;
    ext_t   e2, sx_ext, sy_ext, err_sum;

    assign item_stall  = out_valid_reg & pixel_stall;
    assign accept      = item_valid & ~item_stall;
    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    // error step
    assign e2     = ext_t'({err_reg, 1'b0});
    assign sx_ext = ext_t'({3'b000, span_x_reg});
    assign sy_ext = ext_t'({3'b000, span_y_reg});
    assign step_x = e2 > -sy_ext;
    assign step_y = e2 < sx_ext;
    assign err_sum = ext_t'({err_reg[ERR_BITS-1], err_reg})
                   - (step_x ? sy_ext : ext_t'(0))
                   + (step_y ? sx_ext : ext_t'(0));

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        err_next    = err_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        unique case (item.op)
            OP_START:
            begin
                cur_x_next  = item.start_x;
                cur_y_next  = item.start_y;
                tgt_x_next  = item.end_x;
                tgt_y_next  = item.end_y;
                neg_x_next  = !(item.start_x < item.end_x);
                neg_y_next  = !(item.start_y < item.end_y);
                span_x_next = neg_x_next ? item.start_x - item.end_x
                                         : item.end_x - item.start_x;
                span_y_next = neg_y_next ? item.start_y - item.end_y
                                         : item.end_y - item.start_y;
                err_next    = err_t'({2'b00, span_x_next}) - err_t'({2'b00, span_y_next});
                red_next    = item.red;
                green_next  = item.green;
                blue_next   = item.blue;
            end
            OP_ADVANCE:
            begin
                if (active_reg)
                begin
                    err_next = err_sum[ERR_BITS-1:0];
                    if (step_x)
                    begin
                        cur_x_next = neg_x_reg ? cur_x_reg - coord_t'(1)
                                               : cur_x_reg + coord_t'(1);
                    end
                    if (step_y)
                    begin
                        cur_y_next = neg_y_reg ? cur_y_reg - coord_t'(1)
                                               : cur_y_reg + coord_t'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign at_end = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);

    always_comb
    begin
        out_next    = '0;
        active_next = active_reg;
        if ((item.op == OP_START) || active_reg)
        begin
            out_next.valid_res   = 1'b1;
            out_next.pixel_x     = cur_x_next;
            out_next.pixel_y     = cur_y_next;
            out_next.pixel_red   = red_next;
            out_next.pixel_green = green_next;
            out_next.pixel_blue  = blue_next;
            out_next.last        = at_end;
            active_next          = !at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (!pixel_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            span_x_reg <= span_x_next;
            span_y_reg <= span_y_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            err_reg    <= err_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            out_reg    <= out_next;
        end
    end

endmodule

`default_nettype wire
